@@ rtl/tpa_pkg.sv @@
// Shared types and constants for the two-pool page allocator.
`default_nettype none
package tpa_pkg;
  localparam int PAGE_W = 52;
  localparam int LEN_W  = 13;
  localparam int CFG_IDX_W = 2;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_RUN  = 2'd1;
  localparam logic [1:0] ST_NO_POOL = 2'd2;
  localparam logic [1:0] ST_NOT_USED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KBASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KCNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UBASE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UCNT  = 2'd3;
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;
endpackage
`default_nettype wire

@@ rtl/two_pool_bitmap_page_allocator_core.sv @@
// Top level of the two-pool first-fit bitmap page allocator.
// Channel | Ports                                  | Direction
// in      | in_valid/in_ready, command..page       | to block
// out     | out_valid/out_ready, status, granted   | from block
// cfg     | cfg_we, cfg_index, cfg_wdata           | to block
// Each page is handled by addressing the one-bit map memory, then testing the read bit.
// Allocate: scan for the first free run of len pages, then mark it used; no run gives ST_NO_RUN.
// Free: check that every page is used, then clear them; zero length or no pool goes straight to the result.
// After reset a clearing pass sets every bit; no transfer is taken until it ends.
// A finished result waits in the output register and holds off the next transfer.
`default_nettype none
module two_pool_bitmap_page_allocator_core
  import tpa_pkg::*;
#(
  parameter int POOL_PAGES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_command,
  input  wire logic              in_from_user_pool,
  input  wire logic [LEN_W-1:0]  in_run_length,
  input  wire logic [PAGE_W-1:0] in_free_page_number,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output logic [PAGE_W-1:0]      out_granted_page_number,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PAGE_W-1:0] cfg_wdata
);
  localparam int AW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int CW = $clog2(POOL_PAGES + 1);
  localparam int IW = (CW > LEN_W ? CW : LEN_W) + 1;
  localparam logic [2:0] S_IDLE = 3'd0, S_SRD = 3'd1, S_SCHK = 3'd2,
                         S_MARK = 3'd3, S_DONE = 3'd4;

  logic [PAGE_W-1:0] kbase_r, ubase_r;
  logic [LEN_W-1:0]  kcnt_r, ucnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kbase_r <= '0; ubase_r <= '0; kcnt_r <= '0; ucnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KBASE: kbase_r <= cfg_wdata;
        REG_KCNT:  kcnt_r  <= cfg_wdata[LEN_W-1:0];
        REG_UBASE: ubase_r <= cfg_wdata;
        REG_UCNT:  ucnt_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end
  function automatic logic [IW-1:0] clamp(input logic [LEN_W-1:0] c);
    if (IW'(c) > IW'(POOL_PAGES)) return IW'(POOL_PAGES);
    return IW'(c);
  endfunction

  logic [2:0]        st_r;
  logic              user_r, free_r;
  logic [IW-1:0]     len_r, cnt_r, i_r, run_r, start_r, k_r;
  logic [PAGE_W-1:0] base_r;
  logic              ov_r;
  logic [1:0]        ost_r;
  logic [PAGE_W-1:0] ogr_r;

  logic [AW-1:0] rd_addr;
  logic k_rd, u_rd, k_done, u_done, wr_en, wr_data;
  logic [AW-1:0] wr_addr;
  assign rd_addr = i_r[AW-1:0];
  assign wr_addr = AW'(start_r + k_r);
  tpa_bitmap #(.DEPTH(POOL_PAGES), .AW(AW)) u_kmap (
    .clk, .rst_n, .rd_addr, .rd_data(k_rd), .wr_en(wr_en && !user_r),
    .wr_addr, .wr_data, .init_done(k_done));
  tpa_bitmap #(.DEPTH(POOL_PAGES), .AW(AW)) u_umap (
    .clk, .rst_n, .rd_addr, .rd_data(u_rd), .wr_en(wr_en && user_r),
    .wr_addr, .wr_data, .init_done(u_done));
  logic bit_q;
  assign bit_q = user_r ? u_rd : k_rd;
  assign wr_en = (st_r == S_MARK);
  assign wr_data = !free_r;

  // free pool lookup
  logic [PAGE_W-1:0] koff, uoff;
  logic kin, uin;
  logic [IW-1:0] kc, uc;
  assign kc = clamp(kcnt_r);
  assign uc = clamp(ucnt_r);
  assign koff = in_free_page_number - kbase_r;
  assign uoff = in_free_page_number - ubase_r;
  assign kin = (in_free_page_number >= kbase_r) && (koff < PAGE_W'(kc));
  assign uin = (in_free_page_number >= ubase_r) && (uoff < PAGE_W'(uc));

  assign in_ready = (st_r == S_IDLE) && k_done && u_done && !ov_r;
  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_granted_page_number = ogr_r;

  logic [IW-1:0] run_nxt;
  assign run_nxt = bit_q ? '0 : run_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_valid && in_ready) begin
          len_r <= IW'(in_run_length);
          run_r <= '0;
          k_r <= '0;
          if (in_command == CMD_ALLOC) begin
            free_r <= 1'b0;
            user_r <= in_from_user_pool;
            base_r <= in_from_user_pool ? ubase_r : kbase_r;
            cnt_r <= in_from_user_pool ? uc : kc;
            i_r <= '0;
            if (in_run_length == '0) begin
              ost_r <= ST_OK;
              ogr_r <= in_from_user_pool ? ubase_r : kbase_r;
              st_r <= S_DONE;
            end else st_r <= S_SRD;
          end else begin
            free_r <= 1'b1;
            ogr_r <= '0;
            if (in_run_length == '0) begin
              ost_r <= ST_OK; st_r <= S_DONE;
            end else if (kin && IW'(in_run_length) <= kc - IW'(koff)) begin
              user_r <= 1'b0; cnt_r <= IW'(koff) + IW'(in_run_length);
              start_r <= IW'(koff); i_r <= IW'(koff); st_r <= S_SRD;
            end else if (!kin && uin && IW'(in_run_length) <= uc - IW'(uoff)) begin
              user_r <= 1'b1; cnt_r <= IW'(uoff) + IW'(in_run_length);
              start_r <= IW'(uoff); i_r <= IW'(uoff); st_r <= S_SRD;
            end else begin
              ost_r <= ST_NO_POOL; st_r <= S_DONE;
            end
          end
        end
        S_SRD: begin
          if (i_r >= cnt_r) begin
            if (free_r) begin ost_r <= ST_OK; k_r <= '0; st_r <= S_MARK; end
            else begin ost_r <= ST_NO_RUN; ogr_r <= '0; st_r <= S_DONE; end
          end else st_r <= S_SCHK;
        end
        S_SCHK: begin
          if (free_r) begin
            if (!bit_q) begin ost_r <= ST_NOT_USED; st_r <= S_DONE; end
            else begin i_r <= i_r + 1'b1; st_r <= S_SRD; end
          end else begin
            run_r <= run_nxt;
            if (run_nxt == len_r) begin
              start_r <= i_r + 1'b1 - len_r;
              ost_r <= ST_OK;
              ogr_r <= base_r + PAGE_W'(i_r + 1'b1 - len_r);
              st_r <= S_MARK;
            end else begin i_r <= i_r + 1'b1; st_r <= S_SRD; end
          end
        end
        S_MARK: begin
          k_r <= k_r + 1'b1;
          if (k_r + 1'b1 == len_r) st_r <= S_DONE;
        end
        S_DONE: if (!ov_r) begin
          ov_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/tpa_bitmap.sv @@
// Used-bit map of one pool: one bit per word, sync read, clearing pass after reset.
`default_nettype none
module tpa_bitmap #(
  parameter int DEPTH = 4096,
  parameter int AW = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [AW-1:0] rd_addr,
  output logic               rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic          wr_data,
  output logic               init_done
);
  logic mem [DEPTH];
  logic [AW-1:0] init_addr_r;
  logic          init_done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_addr_r <= '0;
      init_done_r <= 1'b0;
    end else if (!init_done_r) begin
      init_addr_r <= init_addr_r + 1'b1;
      if (init_addr_r == AW'(DEPTH - 1)) init_done_r <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (!init_done_r) mem[init_addr_r] <= 1'b1;
    else if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
  assign init_done = init_done_r;
endmodule
`default_nettype wire

@@ rtl/tpa_checker.sv @@
// Port-level assertions for the page allocator, bound to the top level.
`default_nettype none
module tpa_checker
  import tpa_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");
  a_no_ready_with_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("ready while result pending");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule
bind two_pool_bitmap_page_allocator_core tpa_checker u_tpa_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_status);
`default_nettype wire

@@ tb/sv/two_pool_bitmap_page_allocator_core_test.sv @@
// Self-checking testbench for the two-pool first-fit bitmap page allocator.
`timescale 1ns / 1ps
module two_pool_bitmap_page_allocator_core_test;
  import tpa_pkg::*;

  localparam int CAP = 4096;
  localparam int TOTAL_ITEMS = 1950;

  typedef struct {
    logic              command;
    logic              from_user;
    logic [LEN_W-1:0]  run_length;
    logic [PAGE_W-1:0] page;
  } page_request_t;

  typedef struct {
    logic [1:0]        status;
    logic [PAGE_W-1:0] granted;
  } page_grant_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_command;
  logic              in_from_user_pool;
  logic [LEN_W-1:0]  in_run_length;
  logic [PAGE_W-1:0] in_free_page_number;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_status;
  logic [PAGE_W-1:0] out_granted_page_number;
  logic              cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAGE_W-1:0] cfg_wdata;

  page_request_t pending_requests[$];
  page_grant_t   expected_grants[$];
  int            error_count;
  int            transfers_in;
  int            send_idle_pct;
  int            recv_idle_pct;

  logic [PAGE_W-1:0] kern_base, user_base;
  logic [LEN_W-1:0]  kern_count, user_count;
  bit                kern_used[CAP];
  bit                user_used[CAP];

  two_pool_bitmap_page_allocator_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_from_user_pool(in_from_user_pool),
    .in_run_length(in_run_length), .in_free_page_number(in_free_page_number),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_granted_page_number(out_granted_page_number),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int clamp_pages(logic [LEN_W-1:0] c);
    return (c > CAP) ? CAP : int'(c);
  endfunction

  function automatic page_grant_t apply_request(page_request_t r);
    page_grant_t g;
    int cnt, run, start, idx, len;
    bit found, all_used, in_kern, in_user;
    logic [PAGE_W-1:0] base;
    g.status = ST_OK;
    g.granted = '0;
    len = int'(r.run_length);
    if (r.command == CMD_ALLOC) begin
      base = r.from_user ? user_base : kern_base;
      cnt = clamp_pages(r.from_user ? user_count : kern_count);
      if (len == 0) begin
        g.granted = base;
      end else begin
        run = 0;
        found = 0;
        start = 0;
        for (int i = 0; i < cnt; i++) begin
          if (r.from_user ? user_used[i] : kern_used[i]) run = 0;
          else run++;
          if (run == len) begin
            start = i + 1 - len;
            found = 1;
            break;
          end
        end
        if (found) begin
          for (int i = start; i < start + len; i++) begin
            if (r.from_user) user_used[i] = 1;
            else kern_used[i] = 1;
          end
          g.granted = base + PAGE_W'(start);
        end else begin
          g.status = ST_NO_RUN;
        end
      end
    end else if (len != 0) begin
      in_kern = (r.page >= kern_base) && ((r.page - kern_base) < clamp_pages(kern_count));
      in_user = !in_kern && (r.page >= user_base)
                && ((r.page - user_base) < clamp_pages(user_count));
      idx = in_kern ? int'(r.page - kern_base) : int'(r.page - user_base);
      cnt = in_kern ? clamp_pages(kern_count) : clamp_pages(user_count);
      if (!(in_kern || in_user) || len > cnt - idx) begin
        g.status = ST_NO_POOL;
      end else begin
        all_used = 1;
        for (int i = idx; i < idx + len; i++)
          if (!(in_kern ? kern_used[i] : user_used[i])) all_used = 0;
        if (!all_used) begin
          g.status = ST_NOT_USED;
        end else begin
          for (int i = idx; i < idx + len; i++) begin
            if (in_kern) kern_used[i] = 0;
            else user_used[i] = 0;
          end
        end
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        page_request_t acc;
        acc.command = in_command;
        acc.from_user = in_from_user_pool;
        acc.run_length = in_run_length;
        acc.page = in_free_page_number;
        expected_grants.push_back(apply_request(acc));
        transfers_in++;
        if (transfers_in < TOTAL_ITEMS / 3) begin
          send_idle_pct = 33;
          recv_idle_pct = 61;
        end else if (transfers_in < 2 * TOTAL_ITEMS / 3) begin
          send_idle_pct = 61;
          recv_idle_pct = 33;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      end
      if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        page_request_t nxt;
        nxt = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_command <= nxt.command;
        in_from_user_pool <= nxt.from_user;
        in_run_length <= nxt.run_length;
        in_free_page_number <= nxt.page;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string field, logic [PAGE_W-1:0] got, logic [PAGE_W-1:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("unexpected transfer", PAGE_W'(out_status), '0);
        end else begin
          page_grant_t want;
          want = expected_grants.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", PAGE_W'(out_status), PAGE_W'(want.status));
          if (out_granted_page_number !== want.granted)
            report_mismatch("granted_page_number", out_granted_page_number, want.granted);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [PAGE_W-1:0] rand_page();
    return PAGE_W'({$urandom, $urandom});
  endfunction

  task automatic push_item(logic cmd, logic usr, int len, logic [PAGE_W-1:0] pg);
    page_request_t r;
    r.command = cmd;
    r.from_user = usr;
    r.run_length = LEN_W'(len);
    r.page = pg;
    pending_requests.push_back(r);
  endtask

  task automatic push_random_item();
    int sel, p, cnt, len;
    logic usr;
    logic [PAGE_W-1:0] base;
    sel = $urandom_range(99);
    p = $urandom_range(99);
    usr = 1'($urandom_range(1));
    base = usr ? user_base : kern_base;
    cnt = clamp_pages(usr ? user_count : kern_count);
    if (sel < 45) begin
      if (p < 70) len = $urandom_range(6, 1);
      else if (p < 78) len = 0;
      else if (p < 96) len = $urandom_range(40, 7);
      else len = $urandom_range(8191);
      push_item(CMD_ALLOC, usr, len, rand_page());
    end else if (sel < 88 && cnt > 0) begin
      len = (p < 5) ? 0 : $urandom_range(6, 1);
      push_item(CMD_FREE, 1'($urandom_range(1)), len,
                base + PAGE_W'($urandom_range(cnt - 1)));
    end else if (p < 50) begin
      push_item(CMD_FREE, usr, $urandom_range(64, 1),
                base + PAGE_W'(cnt) - PAGE_W'($urandom_range(3)));
    end else begin
      push_item(CMD_FREE, usr, $urandom_range(8191), rand_page());
    end
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || expected_grants.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAGE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_KBASE: kern_base = val;
      REG_KCNT:  kern_count = val[LEN_W-1:0];
      REG_UBASE: user_base = val;
      REG_UCNT:  user_count = val[LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic start_phase(logic [PAGE_W-1:0] kb, logic [PAGE_W-1:0] kc,
                             logic [PAGE_W-1:0] ub, logic [PAGE_W-1:0] uc);
    wait_idle();
    write_reg(REG_KBASE, kb);
    write_reg(REG_KCNT, kc);
    write_reg(REG_UBASE, ub);
    write_reg(REG_UCNT, uc);
    if (clamp_pages(kern_count) > 0)
      push_item(CMD_FREE, 1'b0, clamp_pages(kern_count), kern_base);
    if (clamp_pages(user_count) > 0)
      push_item(CMD_FREE, 1'b1, clamp_pages(user_count), user_base);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_ALLOC;
    in_from_user_pool = 1'b0;
    in_run_length = '0;
    in_free_page_number = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_KBASE;
    cfg_wdata = '0;
    error_count = 0;
    transfers_in = 0;
    send_idle_pct = 33;
    recv_idle_pct = 61;
    kern_base = '0;
    user_base = '0;
    kern_count = '0;
    user_count = '0;
    for (int i = 0; i < CAP; i++) begin
      kern_used[i] = 1;
      user_used[i] = 1;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    push_item(CMD_ALLOC, 1'b0, 0, '0);
    push_item(CMD_ALLOC, 1'b1, 1, '0);
    push_item(CMD_FREE, 1'b0, 0, '1);
    push_item(CMD_FREE, 1'b1, 1, 52'd5);
    repeat (8) push_random_item();

    start_phase(52'd100, 52'd40, {PAGE_W{1'b1}} - 52'd19, 52'd50);
    push_item(CMD_ALLOC, 1'b0, 0, '1);
    push_item(CMD_ALLOC, 1'b1, 1, '0);
    push_item(CMD_ALLOC, 1'b1, 30, '0);
    push_item(CMD_ALLOC, 1'b0, 4096, '0);
    push_item(CMD_ALLOC, 1'b0, 8191, '0);
    push_item(CMD_ALLOC, 1'b0, 40, '0);
    push_item(CMD_ALLOC, 1'b0, 1, '0);
    push_item(CMD_FREE, 1'b1, 5, 52'd136);
    push_item(CMD_FREE, 1'b0, 5, 52'd135);
    push_item(CMD_FREE, 1'b0, 5, 52'd135);
    push_item(CMD_FREE, 1'b0, 1, {PAGE_W{1'b1}});
    push_item(CMD_FREE, 1'b0, 1, 52'd99);
    push_item(CMD_FREE, 1'b1, 3, {PAGE_W{1'b1}} - 52'd19);
    repeat (600) push_random_item();

    start_phase(52'd0, 52'd8191, 52'd4000, 52'd100);
    push_item(CMD_ALLOC, 1'b0, 4096, '0);
    push_item(CMD_ALLOC, 1'b0, 4097, '0);
    push_item(CMD_FREE, 1'b0, 4096, 52'd0);
    repeat (30) push_random_item();

    start_phase(52'd5000, 52'd64, 52'd5064, 52'd64);
    repeat (1000) push_random_item();

    start_phase({PAGE_W{1'b1}}, 52'd1, 52'd12345, 52'd4096);
    push_item(CMD_ALLOC, 1'b0, 1, '0);
    push_item(CMD_ALLOC, 1'b0, 1, '0);
    repeat (30) push_random_item();

    start_phase(52'd1000, 52'd24, 52'd2000, 52'd0);
    repeat (240) push_random_item();

    wait_idle();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS two_pool_bitmap_page_allocator_core");
    end else begin
      $display("FAIL two_pool_bitmap_page_allocator_core");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("FAIL two_pool_bitmap_page_allocator_core");
    $finish;
  end

endmodule

@@ two_pool_bitmap_page_allocator_core.f @@
rtl/tpa_pkg.sv
rtl/tpa_bitmap.sv
rtl/two_pool_bitmap_page_allocator_core.sv
rtl/tpa_checker.sv
tb/sv/two_pool_bitmap_page_allocator_core_test.sv
